// ===== rtl/dfsm_pkg.sv =====
`timescale 1ns / 1ps

package dfsm_pkg;

   localparam int DEF_MAX_ROWS = 32;
   localparam int DEF_MAX_COLS = 32;

   localparam int REG_W  = 6;
   localparam int CNT_W  = 9;
   localparam int CELL_W = 3;

   localparam int CB_VISITED = 0;
   localparam int CB_BOTTOM  = 1;
   localparam int CB_LEFT    = 2;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] random_value;
      logic [4:0]  cell_row;
      logic [4:0]  cell_col;
   } req_type;

   typedef struct packed {
      logic       moved;
      logic [4:0] new_row;
      logic [4:0] new_col;
      logic       south_wall;
      logic       west_wall;
      logic       done_res;
   } rsp_type;

   // base-4 digit sum, then fold
   function automatic logic [1:0] mod3_16(input logic [15:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

   // position of the k-th set bit
   function automatic logic [1:0] pick_nth(input logic [3:0] cand, input logic [1:0] k);
      logic [1:0] seen;
      logic [1:0] dir;
      logic       found;
      seen  = '0;
      dir   = '0;
      found = 1'b0;
      for (int d = 0; d < 4; d++) begin
         if (cand[d] && !found) begin
            if (seen == k) begin
               dir   = 2'(d);
               found = 1'b1;
            end else begin
               seen = seen + 2'd1;
            end
         end
      end
      return dir;
   endfunction

endpackage

// ===== rtl/dfsm_ram.sv =====
`timescale 1ns / 1ps

module dfsm_ram #(
   parameter int WIDTH  = 3,
   parameter int AWIDTH = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AWIDTH-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [AWIDTH-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [1 << AWIDTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dfsm_walk.sv =====
`timescale 1ns / 1ps

module dfsm_walk import dfsm_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic [CNT_W-1:0] rows_eff,
   input  logic [CNT_W-1:0] cols_eff,
   output logic             res_valid,
   input  logic             res_ready,
   output rsp_type          res_data
);

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RW + CW;
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int SAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int DW    = $clog2(CELLS + 1);

   typedef enum logic [8:0] {
      S_SWEEP = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_TOP   = 9'b000000100,
      S_SCAN  = 9'b000001000,
      S_LAST  = 9'b000010000,
      S_PUSH  = 9'b000100000,
      S_WTOP  = 9'b001000000,
      S_RDC   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              mark_ff, mark_in;
   logic [DW-1:0]     depth_ff, depth_in;
   logic              finished_ff, finished_in;
   req_type           req_ff, req_in;
   logic [RW-1:0]     top_row_ff, top_row_in;
   logic [CW-1:0]     top_col_ff, top_col_in;
   logic [2:0]        scan_ff, scan_in;
   logic [1:0]        dir_ff, dir_in;
   rsp_type           rsp_ff, rsp_in;
   logic [CELL_W-1:0] val_ff [5];
   logic [CELL_W-1:0] val_in [5];

   logic              cell_we;
   logic [AW-1:0]     cell_waddr, cell_raddr;
   logic [CELL_W-1:0] cell_wdata, cell_rdata;
   logic              stk_we;
   logic [SAW-1:0]    stk_waddr, stk_raddr;
   logic [AW-1:0]     stk_wdata, stk_rdata;

   logic [RW-1:0]     nb_row [4];
   logic [CW-1:0]     nb_col [4];
   logic [3:0]        nb_ok;
   logic              row_ok, col_ok;
   logic [3:0]        cand;
   logic [2:0]        cand_cnt;
   logic [1:0]        pick_k;
   logic [1:0]        dir_sel;
   logic [1:0]        scan_sel;
   logic [AW-1:0]     scan_addr;
   logic [DW-1:0]     depth_dec;
   logic              full;
   logic [RW-1:0]     sw_row;
   logic [CW-1:0]     sw_col;
   logic              rd_in_range;
   logic [CELL_W-1:0] nb_val;

   dfsm_ram #(.WIDTH(CELL_W), .AWIDTH(AW)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   dfsm_ram #(.WIDTH(AW), .AWIDTH(SAW)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // neighbors of the top cell, each checked against the rows and columns in use
   always_comb begin
      nb_row[DIR_LEFT]  = top_row_ff;
      nb_col[DIR_LEFT]  = top_col_ff - CW'(1);
      nb_row[DIR_UP]    = top_row_ff - RW'(1);
      nb_col[DIR_UP]    = top_col_ff;
      nb_row[DIR_RIGHT] = top_row_ff;
      nb_col[DIR_RIGHT] = top_col_ff + CW'(1);
      nb_row[DIR_DOWN]  = top_row_ff + RW'(1);
      nb_col[DIR_DOWN]  = top_col_ff;
      row_ok            = CNT_W'(top_row_ff) < rows_eff;
      col_ok            = CNT_W'(top_col_ff) < cols_eff;
      nb_ok[DIR_LEFT]   = (top_col_ff != '0) && row_ok && (CNT_W'(top_col_ff) <= cols_eff);
      nb_ok[DIR_UP]     = (top_row_ff != '0) && col_ok && (CNT_W'(top_row_ff) <= rows_eff);
      nb_ok[DIR_RIGHT]  = row_ok && ((CNT_W'(top_col_ff) + CNT_W'(1)) < cols_eff);
      nb_ok[DIR_DOWN]   = col_ok && ((CNT_W'(top_row_ff) + CNT_W'(1)) < rows_eff);
   end

   always_comb begin
      for (int d = 0; d < 4; d++) begin
         cand[d] = nb_ok[d] && !val_ff[d + 1][CB_VISITED];
      end
      cand_cnt = 3'($countones(cand));
      case (cand_cnt)
         3'd2:    pick_k = {1'b0, req_ff.random_value[0]};
         3'd3:    pick_k = mod3_16(req_ff.random_value);
         3'd4:    pick_k = req_ff.random_value[1:0];
         default: pick_k = 2'd0;
      endcase
      dir_sel   = pick_nth(cand, pick_k);
      nb_val    = val_ff[3'(dir_sel) + 3'd1];
      scan_sel  = 2'(scan_ff - 3'd1);
      scan_addr = (scan_ff == 3'd0) ? {top_row_ff, top_col_ff}
                                    : {nb_row[scan_sel], nb_col[scan_sel]};
      depth_dec = depth_ff - DW'(1);
      full      = depth_ff >= DW'(CELLS);
      sw_row    = sweep_ff[AW-1 -: RW];
      sw_col    = sweep_ff[CW-1:0];
      rd_in_range = (CNT_W'(req_data.cell_row) < CNT_W'(MAX_ROWS))
                 && (CNT_W'(req_data.cell_col) < CNT_W'(MAX_COLS));
   end

   assign req_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_OUT;
   assign res_data  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      mark_in     = mark_ff;
      depth_in    = depth_ff;
      finished_in = finished_ff;
      req_in      = req_ff;
      top_row_in  = top_row_ff;
      top_col_in  = top_col_ff;
      scan_in     = scan_ff;
      dir_in      = dir_ff;
      rsp_in      = rsp_ff;
      val_in      = val_ff;

      cell_we    = 1'b0;
      cell_waddr = sweep_ff;
      cell_wdata = '0;
      cell_raddr = scan_addr;
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[SAW-1:0];
      stk_wdata  = {nb_row[dir_sel], nb_col[dir_sel]};
      stk_raddr  = depth_dec[SAW-1:0];

      case (state_ff)
         S_SWEEP: begin
            cell_we                 = 1'b1;
            cell_wdata[CB_BOTTOM]   = sw_row != '0;
            cell_wdata[CB_LEFT]     = sw_col != '0;
            cell_wdata[CB_VISITED]  = mark_ff && (sweep_ff == '0);
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == '1) begin
               state_in = mark_ff ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            cell_raddr = {RW'(req_data.cell_row), CW'(req_data.cell_col)};
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               case (req_data.op)
                  OP_START: begin
                     stk_we      = 1'b1;
                     stk_waddr   = '0;
                     stk_wdata   = '0;
                     depth_in    = DW'(1);
                     finished_in = 1'b0;
                     mark_in     = 1'b1;
                     sweep_in    = '0;
                     state_in    = S_SWEEP;
                  end
                  OP_STEP: begin
                     if (depth_ff == '0) begin
                        finished_in     = 1'b1;
                        rsp_in.done_res = 1'b1;
                        state_in        = S_OUT;
                     end else begin
                        state_in = S_TOP;
                     end
                  end
                  OP_READ: begin
                     rsp_in.new_row  = req_data.cell_row;
                     rsp_in.new_col  = req_data.cell_col;
                     rsp_in.done_res = finished_ff;
                     state_in        = rd_in_range ? S_RDC : S_OUT;
                  end
                  default: begin
                     rsp_in.done_res = finished_ff;
                     state_in        = S_OUT;
                  end
               endcase
            end
         end
         S_TOP: begin
            top_row_in = stk_rdata[AW-1 -: RW];
            top_col_in = stk_rdata[CW-1:0];
            scan_in    = 3'd0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (scan_ff != 3'd0) begin
               val_in[scan_ff - 3'd1] = cell_rdata;
            end
            scan_in = scan_ff + 3'd1;
            if (scan_ff == 3'd4) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            val_in[4] = cell_rdata;
            state_in  = S_PUSH;
         end
         S_PUSH: begin
            rsp_in = '0;
            if (cand_cnt != 3'd0 && !full) begin
               cell_we    = 1'b1;
               cell_waddr = {nb_row[dir_sel], nb_col[dir_sel]};
               cell_wdata = nb_val;
               cell_wdata[CB_VISITED] = 1'b1;
               if (dir_sel == DIR_RIGHT) begin
                  cell_wdata[CB_LEFT] = 1'b0;
               end
               if (dir_sel == DIR_DOWN) begin
                  cell_wdata[CB_BOTTOM] = 1'b0;
               end
               stk_we         = 1'b1;
               depth_in       = depth_ff + DW'(1);
               dir_in         = dir_sel;
               rsp_in.moved   = 1'b1;
               rsp_in.new_row = 5'(nb_row[dir_sel]);
               rsp_in.new_col = 5'(nb_col[dir_sel]);
               state_in = (dir_sel == DIR_LEFT || dir_sel == DIR_UP) ? S_WTOP : S_OUT;
            end else begin
               depth_in        = depth_dec;
               rsp_in.done_res = depth_dec == '0;
               if (depth_dec == '0) begin
                  finished_in = 1'b1;
               end
               state_in = S_OUT;
            end
         end
         S_WTOP: begin
            cell_we    = 1'b1;
            cell_waddr = {top_row_ff, top_col_ff};
            cell_wdata = val_ff[0];
            if (dir_ff == DIR_LEFT) begin
               cell_wdata[CB_LEFT] = 1'b0;
            end else begin
               cell_wdata[CB_BOTTOM] = 1'b0;
            end
            state_in = S_OUT;
         end
         S_RDC: begin
            rsp_in.south_wall = cell_rdata[CB_BOTTOM];
            rsp_in.west_wall  = cell_rdata[CB_LEFT];
            state_in          = S_OUT;
         end
         S_OUT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_SWEEP;
         sweep_ff    <= '0;
         mark_ff     <= 1'b0;
         depth_ff    <= '0;
         finished_ff <= 1'b1;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         mark_ff     <= mark_in;
         depth_ff    <= depth_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      top_row_ff <= top_row_in;
      top_col_ff <= top_col_in;
      scan_ff    <= scan_in;
      dir_ff     <= dir_in;
      rsp_ff     <= rsp_in;
      val_ff     <= val_in;
   end

endmodule

// ===== rtl/dfs_maze_generator_core.sv =====
`timescale 1ns / 1ps

// Randomized depth-first maze builder over a grid of up to MAX_ROWS x MAX_COLS cells. Cell
// walls and visited bits live in a single-port-write, registered-read cell memory; the walk
// stack lives in a second memory of the same kind. After reset, and after every start word,
// all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cell memory entries (1024 at the default size) are
// swept one entry per cycle with req_ready low. A step word does one stack read, then reads
// the top cell and its four neighbors one per cycle through the cell memory read port, then
// writes the new cell back and, for a move left or up, also the top cell; a step that
// backtracks writes nothing. Each word gives one result word, held in an output register so
// the next word can be accepted while it waits.
module dfs_maze_generator_core import dfsm_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [REG_W-1:0] csr_wdata
);

   logic [REG_W-1:0] row_count_ff, row_count_in;
   logic [REG_W-1:0] col_count_ff, col_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0] rows_eff, cols_eff;
   logic             res_valid, res_ready;
   rsp_type          res_data;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // zero acts as one, large values clamp to the grid size
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = CNT_W'(1);
      end else if (CNT_W'(row_count_ff) > CNT_W'(MAX_ROWS)) begin
         rows_eff = CNT_W'(MAX_ROWS);
      end else begin
         rows_eff = CNT_W'(row_count_ff);
      end
      if (col_count_ff == '0) begin
         cols_eff = CNT_W'(1);
      end else if (CNT_W'(col_count_ff) > CNT_W'(MAX_COLS)) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = CNT_W'(col_count_ff);
      end
   end

   dfsm_walk #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_walk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rows_eff  (rows_eff),
      .cols_eff  (cols_eff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= REG_W'(32);
         col_count_ff <= REG_W'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import dfsm_pkg::*;

   localparam int CELL_TOTAL = DEF_MAX_ROWS * DEF_MAX_COLS;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASE_CAP = 200;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      req_type w;
      bit      typed;
      rsp_type exp;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [REG_W-1:0] csr_wdata;

   // maze model state
   logic [CELL_W-1:0] maze_cells [CELL_TOTAL];
   logic [9:0]        walk_trail [CELL_TOTAL];
   int                trail_depth;
   bit                maze_done;
   logic [REG_W-1:0]  row_reg;
   logic [REG_W-1:0]  col_reg;

   rsp_type      maze_rsp_q [$];
   stim_row_type plan [$];
   int           fault_count;
   int           items_sent;
   int           cycle_count;
   int           rsp_hold;
   bit           calm;

   dfs_maze_generator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) begin
         return 0;
      end else if (p < 85) begin
         return $urandom_range(1, 3);
      end else if (p < 97) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(16, 60);
   endfunction

   function automatic int eff_count(input logic [REG_W-1:0] v, input int cap);
      if (v == 0) begin
         return 1;
      end else if (int'(v) > cap) begin
         return cap;
      end
      return int'(v);
   endfunction

   function automatic void clear_cells();
      for (int r = 0; r < DEF_MAX_ROWS; r++) begin
         for (int c = 0; c < DEF_MAX_COLS; c++) begin
            maze_cells[r * DEF_MAX_COLS + c] = '0;
            maze_cells[r * DEF_MAX_COLS + c][CB_BOTTOM] = (r != 0);
            maze_cells[r * DEF_MAX_COLS + c][CB_LEFT] = (c != 0);
         end
      end
   endfunction

   function automatic req_type mk_word(input logic [1:0] op, input int rnd, input int r,
                                       input int c);
      req_type w;
      w.op = op;
      w.random_value = 16'(rnd);
      w.cell_row = 5'(r);
      w.cell_col = 5'(c);
      return w;
   endfunction

   function automatic rsp_type mk_rsp(input bit moved, input int r, input int c,
                                      input bit bot, input bit lft, input bit done);
      rsp_type e;
      e.moved = moved;
      e.new_row = 5'(r);
      e.new_col = 5'(c);
      e.south_wall = bot;
      e.west_wall = lft;
      e.done_res = done;
      return e;
   endfunction

   // one word through the maze model, state updated in place
   function automatic rsp_type advance_maze(input req_type w);
      rsp_type res;
      int rows, cols, top, r, c, m, k, n, ni;
      logic [1:0] cand [4];
      logic [1:0] dir;
      res = '0;
      rows = eff_count(row_reg, DEF_MAX_ROWS);
      cols = eff_count(col_reg, DEF_MAX_COLS);
      case (w.op)
         OP_START: begin
            clear_cells();
            maze_cells[0][CB_VISITED] = 1'b1;
            walk_trail[0] = '0;
            trail_depth = 1;
            maze_done = 1'b0;
         end
         OP_STEP: begin
            if (trail_depth == 0) begin
               maze_done = 1'b1;
               res.done_res = 1'b1;
            end else begin
               top = int'(walk_trail[trail_depth - 1]);
               r = top / DEF_MAX_COLS;
               c = top % DEF_MAX_COLS;
               n = 0;
               for (int d = 0; d < 4; d++) begin
                  case (2'(d))
                     DIR_LEFT: begin m = r; k = c - 1; end
                     DIR_UP: begin m = r - 1; k = c; end
                     DIR_RIGHT: begin m = r; k = c + 1; end
                     default: begin m = r + 1; k = c; end
                  endcase
                  if (m >= 0 && k >= 0 && m < rows && k < cols) begin
                     if (!maze_cells[m * DEF_MAX_COLS + k][CB_VISITED]) begin
                        cand[n] = 2'(d);
                        n++;
                     end
                  end
               end
               if (n > 0 && trail_depth < CELL_TOTAL) begin
                  dir = cand[int'(w.random_value) % n];
                  case (dir)
                     DIR_LEFT: begin m = r; k = c - 1; end
                     DIR_UP: begin m = r - 1; k = c; end
                     DIR_RIGHT: begin m = r; k = c + 1; end
                     default: begin m = r + 1; k = c; end
                  endcase
                  ni = m * DEF_MAX_COLS + k;
                  case (dir)
                     DIR_LEFT: maze_cells[top][CB_LEFT] = 1'b0;
                     DIR_UP: maze_cells[top][CB_BOTTOM] = 1'b0;
                     DIR_RIGHT: maze_cells[ni][CB_LEFT] = 1'b0;
                     default: maze_cells[ni][CB_BOTTOM] = 1'b0;
                  endcase
                  maze_cells[ni][CB_VISITED] = 1'b1;
                  walk_trail[trail_depth] = 10'(ni);
                  trail_depth++;
                  res.moved = 1'b1;
                  res.new_row = 5'(m);
                  res.new_col = 5'(k);
               end else begin
                  trail_depth--;
                  if (trail_depth == 0) begin
                     maze_done = 1'b1;
                  end
                  res.done_res = maze_done;
               end
            end
         end
         OP_READ: begin
            res.new_row = w.cell_row;
            res.new_col = w.cell_col;
            if (int'(w.cell_row) < DEF_MAX_ROWS && int'(w.cell_col) < DEF_MAX_COLS) begin
               res.south_wall =
                  maze_cells[int'(w.cell_row) * DEF_MAX_COLS + int'(w.cell_col)][CB_BOTTOM];
               res.west_wall =
                  maze_cells[int'(w.cell_row) * DEF_MAX_COLS + int'(w.cell_col)][CB_LEFT];
            end
            res.done_res = maze_done;
         end
         default: begin
            res.done_res = maze_done;
         end
      endcase
      return res;
   endfunction

   task automatic add_row(input req_type w, input bit typed, input rsp_type exp);
      stim_row_type row;
      row.w = w;
      row.typed = typed;
      row.exp = exp;
      plan.push_back(row);
   endtask

   task automatic send_word(input req_type w, input bit typed, input rsp_type exp);
      rsp_type predicted;
      int gap;
      gap = calm ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_maze(w);
      maze_rsp_q.push_back(typed ? exp : predicted);
      items_sent++;
   endtask

   task automatic settle(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (maze_rsp_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ROW_COUNT) begin
         row_reg = value;
      end else begin
         col_reg = value;
      end
   endtask

   function automatic logic [REG_W-1:0] pick_count();
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd32;
            3: return 6'd33;
            4: return 6'd63;
            default: return 6'($urandom_range(0, 63));
         endcase
      end
      return 6'($urandom_range(1, 6));
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (maze_rsp_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("%0t unexpected word moved=%0d row=%0d col=%0d bot=%0d left=%0d done=%0d",
                        $time, rsp_data.moved, rsp_data.new_row, rsp_data.new_col,
                        rsp_data.south_wall, rsp_data.west_wall, rsp_data.done_res);
            end
         end else begin
            exp = maze_rsp_q.pop_front();
            if (rsp_data.moved !== exp.moved || rsp_data.new_row !== exp.new_row ||
                rsp_data.new_col !== exp.new_col || rsp_data.south_wall !== exp.south_wall ||
                rsp_data.west_wall !== exp.west_wall || rsp_data.done_res !== exp.done_res) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("%0t exp moved=%0d row=%0d col=%0d bot=%0d left=%0d done=%0d",
                           $time, exp.moved, exp.new_row, exp.new_col, exp.south_wall,
                           exp.west_wall, exp.done_res);
                  $display("%0t got moved=%0d row=%0d col=%0d bot=%0d left=%0d done=%0d",
                           $time, rsp_data.moved, rsp_data.new_row, rsp_data.new_col,
                           rsp_data.south_wall, rsp_data.west_wall, rsp_data.done_res);
               end
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [REG_W-1:0] fix_rows [7];
      logic [REG_W-1:0] fix_cols [7];
      req_type w;
      int phase, rows, cols, p, tail, tail_goal, phase_items;
      fix_rows = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd1, 6'd33, 6'd32};
      fix_cols = '{6'd1, 6'd63, 6'd0, 6'd1, 6'd32, 6'd2, 6'd32};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_wdata = '0;
      rsp_hold = 0;
      calm = 1'b0;
      fault_count = 0;
      items_sent = 0;
      cycle_count = 0;
      clear_cells();
      for (int i = 0; i < CELL_TOTAL; i++) begin
         walk_trail[i] = '0;
      end
      trail_depth = 0;
      maze_done = 1'b1;
      row_reg = 6'd32;
      col_reg = 6'd32;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      add_row(mk_word(OP_STEP, 16'h1234, 3, 4), 1, mk_rsp(0, 0, 0, 0, 0, 1));
      add_row(mk_word(OP_READ, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 1));
      add_row(mk_word(OP_READ, 16'hffff, 31, 31), 1, mk_rsp(0, 31, 31, 1, 1, 1));
      add_row(mk_word(OP_READ, 0, 0, 31), 1, mk_rsp(0, 0, 31, 0, 1, 1));
      add_row(mk_word(OP_READ, 0, 31, 0), 1, mk_rsp(0, 31, 0, 1, 0, 1));
      add_row(mk_word(OP_UNUSED, 16'hffff, 31, 31), 1, mk_rsp(0, 0, 0, 0, 0, 1));
      add_row(mk_word(OP_START, 16'hffff, 31, 31), 1, mk_rsp(0, 0, 0, 0, 0, 0));
      add_row(mk_word(OP_UNUSED, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0));
      add_row(mk_word(OP_READ, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0));
      add_row(mk_word(OP_STEP, 0, 0, 0), 0, '0);
      add_row(mk_word(OP_STEP, 16'hffff, 0, 0), 0, '0);
      add_row(mk_word(OP_STEP, 1, 0, 0), 0, '0);
      add_row(mk_word(OP_STEP, 2, 0, 0), 0, '0);
      add_row(mk_word(OP_READ, 0, 0, 1), 0, '0);
      add_row(mk_word(OP_READ, 0, 1, 0), 0, '0);
      add_row(mk_word(OP_STEP, 3, 0, 0), 0, '0);
      add_row(mk_word(OP_STEP, 16'h8000, 0, 0), 0, '0);
      add_row(mk_word(OP_STEP, 16'h5555, 0, 0), 0, '0);
      add_row(mk_word(OP_STEP, 16'haaaa, 0, 0), 0, '0);
      add_row(mk_word(OP_STEP, 16'h7fff, 0, 0), 0, '0);
      add_row(mk_word(OP_READ, 0, 1, 1), 0, '0);
      add_row(mk_word(OP_START, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0));
      add_row(mk_word(OP_STEP, 16'hfffe, 0, 0), 0, '0);
      add_row(mk_word(OP_READ, 0, 0, 0), 0, '0);
      foreach (plan[i]) begin
         send_word(plan[i].w, plan[i].typed, plan[i].exp);
      end

      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         settle(16);
         calm = ($urandom_range(0, 3) == 0);
         if (phase < 7) begin
            write_reg(CSR_ROW_COUNT, fix_rows[phase]);
            write_reg(CSR_COL_COUNT, fix_cols[phase]);
         end else begin
            write_reg(CSR_COL_COUNT, pick_count());
            write_reg(CSR_ROW_COUNT, pick_count());
         end
         rows = eff_count(row_reg, DEF_MAX_ROWS);
         cols = eff_count(col_reg, DEF_MAX_COLS);
         if (phase < 7 || trail_depth == 0 || $urandom_range(0, 4) != 0) begin
            send_word(mk_word(OP_START, $urandom_range(0, 65535), $urandom_range(0, 31),
                              $urandom_range(0, 31)), 0, '0);
         end
         tail = 0;
         tail_goal = $urandom_range(1, 3);
         phase_items = 0;
         while (tail < tail_goal && phase_items < PHASE_CAP) begin
            w = mk_word(OP_STEP, $urandom_range(0, 65535), $urandom_range(0, 31),
                        $urandom_range(0, 31));
            p = $urandom_range(0, 99);
            if (p >= 72 && p < 90) begin
               w.op = OP_READ;
               if ($urandom_range(0, 1) == 1) begin
                  w.cell_row = 5'($urandom_range(0, rows - 1));
                  w.cell_col = 5'($urandom_range(0, cols - 1));
               end
            end else if (p >= 90 && p < 95) begin
               w.op = OP_UNUSED;
            end else if (p >= 95 && p < 97) begin
               w.op = OP_START;
            end else if (p >= 97) begin
               w.random_value = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            end
            send_word(w, 0, '0);
            phase_items++;
            if (maze_done) begin
               tail++;
            end
         end
         phase++;
      end

      calm = 1'b0;
      settle(40);
      if (fault_count == 0 && maze_rsp_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== dfs_maze_generator_core.f =====
rtl/dfsm_pkg.sv
rtl/dfsm_ram.sv
rtl/dfsm_walk.sv
rtl/dfs_maze_generator_core.sv
tb/testbench.sv
